// ===== hw/rtl/ffal_pkg.sv =====
package ffal_pkg;

  localparam int unsigned ADDR_W     = 12;
  localparam int unsigned HEAP_UNITS = 1 << ADDR_W;
  localparam int unsigned UNIT_BYTES = 4;
  localparam int unsigned UNIT_SH    = $clog2(UNIT_BYTES);
  localparam int unsigned BYTES_W    = 16;
  localparam int unsigned NEED_W     = BYTES_W - UNIT_SH + 1;
  localparam int unsigned CNT_W      = ADDR_W + 1;
  localparam logic [CNT_W-1:0] WALK_LAST = CNT_W'(HEAP_UNITS);

  typedef logic [ADDR_W-1:0] addr_t;

  typedef enum logic [1:0] {
    ACT_ALLOC   = 2'd0,
    ACT_RELEASE = 2'd1,
    ACT_INIT    = 2'd2,
    ACT_NONE    = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_OOM    = 2'd1,
    STAT_NOINIT = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ALLOC_GO,
    ST_ALLOC_EVAL,
    ST_SPLIT_TAIL,
    ST_REL_EVAL,
    ST_REL_RD_NX,
    ST_REL_MERGE_HI,
    ST_REL_RD_P,
    ST_REL_RD_BLK,
    ST_REL_MERGE_LO,
    ST_INIT_HI,
    ST_INIT_LO
  } state_e;

  typedef enum logic [4:0] {
    CMD_NOP,
    CMD_FIN_OK,
    CMD_FIN_OOM,
    CMD_FIN_NOINIT,
    CMD_ALLOC_START,
    CMD_ALLOC_FIRST,
    CMD_ALLOC_NEXT,
    CMD_UNLINK,
    CMD_SPLIT_HEAD,
    CMD_SPLIT_TAIL,
    CMD_REL_START,
    CMD_REL_NEXT,
    CMD_REL_FOUND,
    CMD_REL_RD_NX,
    CMD_MERGE_HI,
    CMD_RD_P,
    CMD_RD_BLK,
    CMD_MERGE_LO,
    CMD_INIT_HI,
    CMD_INIT_LO
  } cmd_e;

  typedef struct packed {
    logic initialized;
    logic addr_zero;
    logic fit;
    logic exact;
    logic at_rover;
    logic walk_end;
    logic found;
  } dp_status_t;

endpackage

// ===== hw/rtl/ffal_dpath.sv =====
module ffal_dpath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ffal_pkg::cmd_e             cmd_i,
  input  logic [15:0]                request_bytes_i,
  input  logic [11:0]                block_address_i,
  input  logic                       heap_units_we_i,
  input  logic [11:0]                heap_units_i,
  output ffal_pkg::dp_status_t       status_o,
  output logic                       done_o,
  output logic [11:0]                granted_address_o,
  output logic [1:0]                 status_code_o
);
  import ffal_pkg::*;

  addr_t link_mem [HEAP_UNITS];
  addr_t size_mem [HEAP_UNITS];

  addr_t              rd_link_q, rd_size_q;
  addr_t              hu_q, rover_q, prev_q, cur_q, blk_q, nx_q, sz_q;
  logic [NEED_W-1:0]  need_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               init_q;
  logic               done_q;
  addr_t              grant_q;
  status_e            stat_q;

  logic               rd_en;
  addr_t              rd_addr;
  logic               link_we, size_we;
  addr_t              wr_addr, link_wd, size_wd;
  logic [BYTES_W:0]   bytes_up;
  logic [NEED_W-1:0]  need_d;
  addr_t              rem, hi_sum, lo_sum;
  logic               hi_join, lo_join;

  assign bytes_up = {1'b0, request_bytes_i} + (BYTES_W + 1)'(UNIT_BYTES - 1);
  assign need_d   = NEED_W'(bytes_up >> UNIT_SH) + NEED_W'(1);
  assign rem      = rd_size_q - need_q[ADDR_W-1:0];
  assign hi_sum   = blk_q + sz_q;
  assign lo_sum   = prev_q + sz_q;
  assign hi_join  = (hi_sum == nx_q);
  assign lo_join  = (lo_sum == blk_q);

  always_comb begin
    status_o.initialized = init_q;
    status_o.addr_zero   = (block_address_i == '0);
    status_o.fit         = ({{(NEED_W - ADDR_W){1'b0}}, rd_size_q} >= need_q);
    status_o.exact       = ({{(NEED_W - ADDR_W){1'b0}}, rd_size_q} == need_q);
    status_o.at_rover    = (cur_q == rover_q);
    status_o.walk_end    = (cnt_q == WALK_LAST);
    status_o.found       = ((blk_q > prev_q) && (blk_q < rd_link_q)) ||
                           ((prev_q >= rd_link_q) &&
                            ((blk_q > prev_q) || (blk_q < rd_link_q)));
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = rd_link_q;
    link_we = 1'b0;
    size_we = 1'b0;
    wr_addr = cur_q;
    link_wd = rd_link_q;
    size_wd = rd_size_q;
    case (cmd_i)
      CMD_ALLOC_START: begin
        rd_en   = 1'b1;
        rd_addr = rover_q;
      end
      CMD_REL_START: begin
        rd_en   = 1'b1;
        rd_addr = rover_q;
      end
      CMD_ALLOC_FIRST, CMD_ALLOC_NEXT, CMD_REL_NEXT: begin
        rd_en   = 1'b1;
        rd_addr = rd_link_q;
      end
      CMD_REL_FOUND: begin
        rd_en   = 1'b1;
        rd_addr = blk_q;
      end
      CMD_REL_RD_NX: begin
        rd_en   = 1'b1;
        rd_addr = nx_q;
      end
      CMD_RD_P: begin
        rd_en   = 1'b1;
        rd_addr = prev_q;
      end
      CMD_RD_BLK: begin
        rd_en   = 1'b1;
        rd_addr = blk_q;
      end
      CMD_UNLINK: begin
        link_we = 1'b1;
        wr_addr = prev_q;
        link_wd = rd_link_q;
      end
      CMD_SPLIT_HEAD: begin
        size_we = 1'b1;
        wr_addr = cur_q;
        size_wd = rem;
      end
      CMD_SPLIT_TAIL: begin
        size_we = 1'b1;
        wr_addr = cur_q;
        size_wd = need_q[ADDR_W-1:0];
      end
      CMD_MERGE_HI: begin
        link_we = 1'b1;
        size_we = hi_join;
        wr_addr = blk_q;
        link_wd = hi_join ? rd_link_q : nx_q;
        size_wd = sz_q + rd_size_q;
      end
      CMD_MERGE_LO: begin
        link_we = 1'b1;
        size_we = lo_join;
        wr_addr = prev_q;
        link_wd = lo_join ? rd_link_q : blk_q;
        size_wd = sz_q + rd_size_q;
      end
      CMD_INIT_HI: begin
        link_we = 1'b1;
        size_we = 1'b1;
        wr_addr = addr_t'(1);
        link_wd = '0;
        size_wd = hu_q;
      end
      CMD_INIT_LO: begin
        link_we = 1'b1;
        size_we = 1'b1;
        wr_addr = '0;
        link_wd = addr_t'(1);
        size_wd = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (link_we) begin
      link_mem[wr_addr] <= link_wd;
    end
    if (size_we) begin
      size_mem[wr_addr] <= size_wd;
    end
    if (rd_en) begin
      rd_link_q <= link_mem[rd_addr];
      rd_size_q <= size_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i)
      CMD_ALLOC_START: begin
        need_q <= need_d;
        prev_q <= rover_q;
        cnt_q  <= '0;
      end
      CMD_ALLOC_FIRST: begin
        cur_q <= rd_link_q;
      end
      CMD_ALLOC_NEXT: begin
        prev_q <= cur_q;
        cur_q  <= rd_link_q;
        cnt_q  <= cnt_q + CNT_W'(1);
      end
      CMD_SPLIT_HEAD: begin
        cur_q <= cur_q + rem;
      end
      CMD_REL_START: begin
        prev_q <= rover_q;
        blk_q  <= block_address_i - addr_t'(1);
        cnt_q  <= '0;
      end
      CMD_REL_NEXT: begin
        prev_q <= rd_link_q;
        cnt_q  <= cnt_q + CNT_W'(1);
      end
      CMD_REL_FOUND: begin
        nx_q <= rd_link_q;
      end
      CMD_REL_RD_NX, CMD_RD_BLK: begin
        sz_q <= rd_size_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hu_q    <= addr_t'(HEAP_UNITS - 1);
      rover_q <= '0;
      init_q  <= 1'b0;
      done_q  <= 1'b0;
      grant_q <= '0;
      stat_q  <= STAT_OK;
    end else begin
      if (heap_units_we_i) begin
        hu_q <= heap_units_i;
      end
      done_q  <= 1'b0;
      grant_q <= '0;
      stat_q  <= STAT_OK;
      case (cmd_i)
        CMD_FIN_OK: begin
          done_q <= 1'b1;
        end
        CMD_FIN_OOM: begin
          done_q <= 1'b1;
          stat_q <= STAT_OOM;
        end
        CMD_FIN_NOINIT: begin
          done_q <= 1'b1;
          stat_q <= STAT_NOINIT;
        end
        CMD_UNLINK, CMD_SPLIT_TAIL: begin
          done_q  <= 1'b1;
          rover_q <= prev_q;
          grant_q <= cur_q + addr_t'(1);
        end
        CMD_MERGE_LO: begin
          done_q  <= 1'b1;
          rover_q <= prev_q;
        end
        CMD_INIT_LO: begin
          done_q  <= 1'b1;
          rover_q <= '0;
          init_q  <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  assign done_o            = done_q;
  assign granted_address_o = grant_q;
  assign status_code_o     = stat_q;

endmodule

// ===== hw/rtl/ffal_ctrl.sv =====
module ffal_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [1:0]            action_i,
  input  ffal_pkg::dp_status_t  status_i,
  output ffal_pkg::cmd_e        cmd_o,
  output logic                  busy_o
);
  import ffal_pkg::*;

  state_e  state_q, state_d;
  action_e act;

  assign act = action_e'(action_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          case (act)
            ACT_INIT:    state_d = ST_INIT_HI;
            ACT_ALLOC:   state_d = status_i.initialized ? ST_ALLOC_GO : ST_IDLE;
            ACT_RELEASE: state_d = (status_i.initialized && !status_i.addr_zero) ?
                                   ST_REL_EVAL : ST_IDLE;
            default:     state_d = ST_IDLE;
          endcase
        end
      end
      ST_ALLOC_GO: state_d = ST_ALLOC_EVAL;
      ST_ALLOC_EVAL: begin
        if (status_i.fit) begin
          state_d = status_i.exact ? ST_IDLE : ST_SPLIT_TAIL;
        end else if (status_i.at_rover || status_i.walk_end) begin
          state_d = ST_IDLE;
        end
      end
      ST_SPLIT_TAIL: state_d = ST_IDLE;
      ST_REL_EVAL: begin
        if (status_i.found) begin
          state_d = ST_REL_RD_NX;
        end else if (status_i.walk_end) begin
          state_d = ST_IDLE;
        end
      end
      ST_REL_RD_NX:    state_d = ST_REL_MERGE_HI;
      ST_REL_MERGE_HI: state_d = ST_REL_RD_P;
      ST_REL_RD_P:     state_d = ST_REL_RD_BLK;
      ST_REL_RD_BLK:   state_d = ST_REL_MERGE_LO;
      ST_REL_MERGE_LO: state_d = ST_IDLE;
      ST_INIT_HI:      state_d = ST_INIT_LO;
      ST_INIT_LO:      state_d = ST_IDLE;
      default:         state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = CMD_NOP;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          case (act)
            ACT_INIT:    cmd_o = CMD_NOP;
            ACT_ALLOC:   cmd_o = status_i.initialized ? CMD_ALLOC_START : CMD_FIN_NOINIT;
            ACT_RELEASE: begin
              if (!status_i.initialized) begin
                cmd_o = CMD_FIN_NOINIT;
              end else if (status_i.addr_zero) begin
                cmd_o = CMD_FIN_OK;
              end else begin
                cmd_o = CMD_REL_START;
              end
            end
            default:     cmd_o = CMD_FIN_OK;
          endcase
        end
      end
      ST_ALLOC_GO: cmd_o = CMD_ALLOC_FIRST;
      ST_ALLOC_EVAL: begin
        if (status_i.fit) begin
          cmd_o = status_i.exact ? CMD_UNLINK : CMD_SPLIT_HEAD;
        end else if (status_i.at_rover || status_i.walk_end) begin
          cmd_o = CMD_FIN_OOM;
        end else begin
          cmd_o = CMD_ALLOC_NEXT;
        end
      end
      ST_SPLIT_TAIL: cmd_o = CMD_SPLIT_TAIL;
      ST_REL_EVAL: begin
        if (status_i.found) begin
          cmd_o = CMD_REL_FOUND;
        end else if (status_i.walk_end) begin
          cmd_o = CMD_FIN_OK;
        end else begin
          cmd_o = CMD_REL_NEXT;
        end
      end
      ST_REL_RD_NX:    cmd_o = CMD_REL_RD_NX;
      ST_REL_MERGE_HI: cmd_o = CMD_MERGE_HI;
      ST_REL_RD_P:     cmd_o = CMD_RD_P;
      ST_REL_RD_BLK:   cmd_o = CMD_RD_BLK;
      ST_REL_MERGE_LO: cmd_o = CMD_MERGE_LO;
      ST_INIT_HI:      cmd_o = CMD_INIT_HI;
      ST_INIT_LO:      cmd_o = CMD_INIT_LO;
      default:         cmd_o = CMD_NOP;
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);

  a_busy_needs_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_o) |-> $past(start_i))
    else $error("Controller left idle without a start.");

  a_eval_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ALLOC_EVAL) |->
      ($past(state_q) == ST_ALLOC_GO || $past(state_q) == ST_ALLOC_EVAL))
    else $error("Allocation evaluation entered out of sequence.");

  a_tail_after_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o == CMD_SPLIT_HEAD) |=> (cmd_o == CMD_SPLIT_TAIL))
    else $error("Split head not followed by split tail.");

  a_unlink_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o == CMD_UNLINK) |=> (state_q == ST_IDLE))
    else $error("Exact fit did not end the allocation.");

endmodule

// ===== hw/rtl/first_fit_free_list_allocator.sv =====
// First-fit heap allocator over 4096 header units. An action is taken when start_i is high
// and busy_o is low, and exactly one result beat follows, marked by done_o for one cycle;
// the receiver cannot stall it, so it must capture granted_address_o and status_o then.
// Allocate and release run the list walk, in which the registered read of the next
// free-list header overlaps the compare on the current one. An allocate walks, then unlinks
// the chosen block or splits it into head and tail; a release walks, then reads the next
// block, merges high, reads the previous and the freed block and merges low; init writes
// two headers; a null release, an unused action or an access before init is answered from
// idle with no walk. The heap must be initialized before use; the header store is not cleared by reset.
module first_fit_free_list_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  action_i,
  input  logic [15:0] request_bytes_i,
  input  logic [11:0] block_address_i,
  input  logic        heap_units_we_i,
  input  logic [11:0] heap_units_i,
  output logic        done_o,
  output logic [11:0] granted_address_o,
  output logic [1:0]  status_o
);
  import ffal_pkg::*;

  cmd_e       cmd;
  dp_status_t dp_status;

  ffal_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .action_i (action_i),
    .status_i (dp_status),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  ffal_dpath u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .request_bytes_i   (request_bytes_i),
    .block_address_i   (block_address_i),
    .heap_units_we_i   (heap_units_we_i),
    .heap_units_i      (heap_units_i),
    .status_o          (dp_status),
    .done_o            (done_o),
    .granted_address_o (granted_address_o),
    .status_code_o     (status_o)
  );

endmodule
